// ===== rtl/core/idpbp_pkg.sv =====
`default_nettype none
package idpbp_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = 10;
    localparam int CNT_W   = 11;
    localparam int LG_W    = 4;
    localparam int SMP_W   = 16;
    localparam int TW_W    = 16;
    localparam int PROD_W  = SMP_W + TW_W;
    localparam int ACC_W   = PROD_W + ADDR_W + 2;
    localparam int POW_W   = 63;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int PEAK_W  = 11;
    localparam int PROBE_W = 10;
    localparam int BAND_W  = 11;
    localparam int QUARTER = MAX_LEN / 4;

    localparam logic [POW_W-1:0] POW_CAP = {POW_W{1'b1}};

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAND_BAD = 2'd2;

    localparam logic [1:0] CFG_PROBE     = 2'd0;
    localparam logic [1:0] CFG_BAND_LOW  = 2'd1;
    localparam logic [1:0] CFG_BAND_HIGH = 2'd2;

    // Taylor series denominators (2n)(2n+1)
    localparam longint unsigned TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic signed [TW_W-1:0] t_sine_rom [0:QUARTER];

    typedef struct packed {
        logic              load_wr;
        logic              rd_en;
        logic              bin_start;
        logic              job_start;
        logic              sq;
        logic              psum;
        logic              upd;
        logic              sqrt_start;
        logic              res_write;
        logic              res_bad;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] k;
        logic [CNT_W-1:0]  len;
        logic [LG_W-1:0]   lg;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic out_free;
    } t_stat;

    // quarter-wave sine, Q30 Taylor series rounded to Q1.15
    function automatic t_sine_rom build_sine();
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            r;
        for (int j = 0; j <= QUARTER; j++) begin
            x = (longint'(j) * 64'd6746518852) / MAX_LEN;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            r = (sum + (64'sd1 <<< (30 - TW_W))) >>> (31 - TW_W);
            if (r > ((64'sd1 <<< (TW_W - 1)) - 1)) r = (64'sd1 <<< (TW_W - 1)) - 1;
            rom[j] = r[TW_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

    function automatic logic signed [TW_W-1:0] sin_at(input logic [ADDR_W-1:0] ph);
        logic [ADDR_W-3:0] r;
        logic [ADDR_W-2:0] rr;
        logic signed [TW_W-1:0] v;
        r = ph[ADDR_W-3:0];
        rr = (ADDR_W-1)'(QUARTER) - {1'b0, r};
        unique case (ph[ADDR_W-1:ADDR_W-2])
            2'd0:    v = SINE_ROM[{1'b0, r}];
            2'd1:    v = SINE_ROM[rr];
            2'd2:    v = -SINE_ROM[{1'b0, r}];
            default: v = -SINE_ROM[rr];
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/iq_dft_peak_band_power_unit.sv =====
// Samples load one beat per cycle while the input is not stalled; a beat with last set
// starts the transform. An N-sample buffer runs, per bin, the MAC, drain, square, sum
// and update states in turn, then a 32-step square root.
// A bad length skips the transform and goes straight to the result state. Input stalls until the
// result enters the output register (longer while the previous one is held there).
// Synchronous active-low reset clears control state and config; the sample buffer is not cleared.
`default_nettype none
module iq_dft_peak_band_power_unit import idpbp_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [SMP_W-1:0]  i_sample_i,
    input  wire logic signed [SMP_W-1:0]  i_sample_q,
    input  wire logic                     i_last,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [BAND_W-1:0]        i_cfg_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [PEAK_W-1:0]      o_max_bin,
    output logic [POW_W-1:0]              o_max_power,
    output logic [SUM_W-1:0]              o_band_power,
    output logic                          o_band_saturated,
    output logic [POW_W-1:0]              o_probe_power,
    output logic [ROOT_W-1:0]             o_probe_magnitude
);
    t_cmd  w_cmd;
    t_stat w_stat;

    idpbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    idpbp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_sample_i        (i_sample_i),
        .i_sample_q        (i_sample_q),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_max_bin         (o_max_bin),
        .o_max_power       (o_max_power),
        .o_band_power      (o_band_power),
        .o_band_saturated  (o_band_saturated),
        .o_probe_power     (o_probe_power),
        .o_probe_magnitude (o_probe_magnitude)
    );
endmodule
`default_nettype wire

// ===== rtl/core/idpbp_isqrt.sv =====
`default_nettype none
module idpbp_isqrt import idpbp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [POW_W-1:0]  i_value,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);
    logic [63:0] r_v, r_res, r_bit;
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    // one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= {1'b0, i_value};
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_v >= w_trial) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/idpbp_datapath.sv =====
`default_nettype none
module idpbp_datapath import idpbp_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    input  wire logic signed [SMP_W-1:0]  i_sample_i,
    input  wire logic signed [SMP_W-1:0]  i_sample_q,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [BAND_W-1:0]        i_cfg_data,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic signed [PEAK_W-1:0]      o_max_bin,
    output logic [POW_W-1:0]              o_max_power,
    output logic [SUM_W-1:0]              o_band_power,
    output logic                          o_band_saturated,
    output logic [POW_W-1:0]              o_probe_power,
    output logic [ROOT_W-1:0]             o_probe_magnitude
);
    // configuration
    logic [PROBE_W-1:0]       r_probe;
    logic signed [BAND_W-1:0] r_band_lo, r_band_hi;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe   <= '0;
            r_band_lo <= -11'sd512;
            r_band_hi <= 11'sd512;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROBE:     r_probe   <= i_cfg_data[PROBE_W-1:0];
                CFG_BAND_LOW:  r_band_lo <= i_cfg_data;
                CFG_BAND_HIGH: r_band_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample buffer
    logic [2*SMP_W-1:0] r_mem [0:MAX_LEN-1];
    logic [2*SMP_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) r_mem[i_cmd.addr] <= {i_sample_i, i_sample_q};
        if (i_cmd.rd_en)   r_rd <= r_mem[i_cmd.addr];
    end

    // MAC pipeline: read, twiddle lookup, products, accumulate
    logic [ADDR_W-1:0]        r_phase, r_ph1, w_inc;
    logic                     r_v1, r_v2, r_v3;
    logic signed [TW_W-1:0]   r_c, r_s;
    logic signed [SMP_W-1:0]  r_xi, r_xq;
    logic signed [PROD_W-1:0] r_p_ic, r_p_qs, r_p_qc, r_p_is;
    logic signed [ACC_W-1:0]  r_re, r_im;

    assign w_inc = i_cmd.k << (LG_W'(ADDR_W) - i_cmd.lg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_start) r_phase <= '0;
        else if (i_cmd.rd_en) r_phase <= r_phase + w_inc;
        if (i_cmd.rd_en) r_ph1 <= r_phase;
        r_c    <= sin_at(r_ph1 + ADDR_W'(QUARTER));
        r_s    <= sin_at(r_ph1);
        r_xi   <= r_rd[2*SMP_W-1:SMP_W];
        r_xq   <= r_rd[SMP_W-1:0];
        r_p_ic <= r_xi * r_c;
        r_p_qs <= r_xq * r_s;
        r_p_qc <= r_xq * r_c;
        r_p_is <= r_xi * r_s;
        if (i_cmd.bin_start) begin
            r_re <= '0;
            r_im <= '0;
        end else if (r_v3) begin
            r_re <= r_re + ACC_W'(r_p_ic) + ACC_W'(r_p_qs);
            r_im <= r_im + ACC_W'(r_p_qc) - ACC_W'(r_p_is);
        end
    end

    // bin power: floor divide by length, square, sum with cap
    logic signed [ACC_W-1:0] w_re_sh, w_im_sh;
    logic [31:0]             w_re_abs, w_im_abs;
    logic [63:0]             r_sq_re, r_sq_im;
    logic [64:0]             w_psum;
    logic [POW_W-1:0]        r_pow;

    assign w_re_sh  = r_re >>> i_cmd.lg;
    assign w_im_sh  = r_im >>> i_cmd.lg;
    assign w_re_abs = w_re_sh[ACC_W-1] ? 32'(-w_re_sh) : 32'(w_re_sh);
    assign w_im_abs = w_im_sh[ACC_W-1] ? 32'(-w_im_sh) : 32'(w_im_sh);
    assign w_psum   = {1'b0, r_sq_re} + {1'b0, r_sq_im};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_sq_re <= w_re_abs * w_re_abs;
            r_sq_im <= w_im_abs * w_im_abs;
        end
        if (i_cmd.psum) r_pow <= (w_psum > 65'(POW_CAP)) ? POW_CAP : w_psum[POW_W-1:0];
    end

    // peak, band and probe tracking
    logic [POW_W-1:0]        r_best, r_probe_pow;
    logic [ADDR_W-1:0]       r_best_bin;
    logic [SUM_W-1:0]        r_band;
    logic                    r_sat;
    logic signed [BAND_W:0]  w_sb;
    logic                    w_band_bad, w_in_band;
    logic [SUM_W:0]          w_band_add;
    logic [ADDR_W-1:0]       w_probe_k;

    assign w_sb = ({1'b0, i_cmd.k} > (i_cmd.len >> 1))
                ? $signed({2'b00, i_cmd.k} - {1'b0, i_cmd.len})
                : $signed({2'b00, i_cmd.k});
    assign w_band_bad = r_band_lo > r_band_hi;
    assign w_in_band  = !w_band_bad && (w_sb >= (BAND_W+1)'(r_band_lo))
                        && (w_sb <= (BAND_W+1)'(r_band_hi));
    assign w_band_add = {1'b0, r_band} + {2'b00, r_pow};
    assign w_probe_k  = r_probe & ADDR_W'(i_cmd.len - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.job_start) begin
            r_best     <= '0;
            r_best_bin <= '0;
            r_band     <= '0;
            r_sat      <= 1'b0;
        end else if (i_cmd.upd) begin
            if (i_cmd.k == '0 || r_pow > r_best) begin
                r_best     <= r_pow;
                r_best_bin <= i_cmd.k;
            end
            if (w_in_band) begin
                if (w_band_add[SUM_W]) begin
                    r_band <= '1;
                    r_sat  <= 1'b1;
                end else begin
                    r_band <= w_band_add[SUM_W-1:0];
                end
            end
            if (i_cmd.k == w_probe_k) r_probe_pow <= r_pow;
        end
    end

    logic              w_sqrt_done;
    logic [ROOT_W-1:0] w_root;

    idpbp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_probe_pow),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // result register
    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic signed [PEAK_W-1:0] r_max_bin, w_peak;
    logic [POW_W-1:0]        r_peak_pow, r_probe_out;
    logic [SUM_W-1:0]        r_band_out;
    logic                    r_sat_out;
    logic [ROOT_W-1:0]       r_root_out;

    assign w_peak = ({1'b0, r_best_bin} > (i_cmd.len >> 1))
                  ? $signed(PEAK_W'({1'b0, r_best_bin} - i_cmd.len))
                  : $signed(PEAK_W'(r_best_bin));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_write) begin
            if (i_cmd.res_bad) begin
                r_status    <= ST_BAD_LEN;
                r_max_bin   <= '0;
                r_peak_pow  <= '0;
                r_band_out  <= '0;
                r_sat_out   <= 1'b0;
                r_probe_out <= '0;
                r_root_out  <= '0;
            end else begin
                r_status    <= w_band_bad ? ST_BAND_BAD : ST_OK;
                r_max_bin   <= w_peak;
                r_peak_pow  <= r_best;
                r_band_out  <= w_band_bad ? '0 : r_band;
                r_sat_out   <= !w_band_bad && r_sat;
                r_probe_out <= r_probe_pow;
                r_root_out  <= w_root;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_max_bin         = r_max_bin;
    assign o_max_power       = r_peak_pow;
    assign o_band_power      = r_band_out;
    assign o_band_saturated  = r_sat_out;
    assign o_probe_power     = r_probe_out;
    assign o_probe_magnitude = r_root_out;

    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
endmodule
`default_nettype wire

// ===== rtl/core/idpbp_ctrl.sv =====
`default_nettype none
module idpbp_ctrl import idpbp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire logic   i_last,
    output logic        o_in_stall,
    input  wire t_stat  i_stat,
    output t_cmd        o_cmd
);
    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_MAC   = 9'b000000010,
        S_DRAIN = 9'b000000100,
        S_SQ    = 9'b000001000,
        S_PSUM  = 9'b000010000,
        S_UPD   = 9'b000100000,
        S_SQST  = 9'b001000000,
        S_SQRT  = 9'b010000000,
        S_RES   = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count, w_cnt_inc;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [LG_W-1:0]   r_lg, n_lg, w_lg;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [1:0]        r_drain, n_drain;
    logic              r_bad, n_bad;
    logic              w_accept, w_good;

    assign w_accept  = i_in_valid && (r_state == S_LOAD);
    assign w_cnt_inc = (r_count < CNT_W'(MAX_LEN)) ? r_count + CNT_W'(1)
                                                   : CNT_W'(MAX_LEN + 1);
    assign w_good    = ((w_cnt_inc & (w_cnt_inc - CNT_W'(1))) == '0)
                       && (w_cnt_inc <= CNT_W'(MAX_LEN));

    always_comb begin
        w_lg = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (w_cnt_inc[i]) w_lg = LG_W'(i);
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_len   = r_len;
        n_lg    = r_lg;
        n_k     = r_k;
        n_n     = r_n;
        n_drain = r_drain;
        n_bad   = r_bad;
        o_cmd   = '0;
        o_cmd.k   = r_k;
        o_cmd.len = r_len;
        o_cmd.lg  = r_lg;
        o_cmd.addr = r_count[ADDR_W-1:0];
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_cmd.load_wr = r_count < CNT_W'(MAX_LEN);
                    n_count = w_cnt_inc;
                    if (i_last) begin
                        n_count = '0;
                        if (w_good) begin
                            n_len   = w_cnt_inc;
                            n_lg    = w_lg;
                            n_k     = '0;
                            n_n     = '0;
                            n_bad   = 1'b0;
                            n_state = S_MAC;
                            o_cmd.job_start = 1'b1;
                            o_cmd.bin_start = 1'b1;
                        end else begin
                            n_bad   = 1'b1;
                            n_state = S_RES;
                        end
                    end
                end
            end
            S_MAC: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.addr  = r_n[ADDR_W-1:0];
                n_n = r_n + CNT_W'(1);
                if (r_n == r_len - CNT_W'(1)) begin
                    n_n     = '0;
                    n_drain = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // let the last products reach the accumulators
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd3) n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_PSUM;
            end
            S_PSUM: begin
                o_cmd.psum = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if ({1'b0, r_k} == r_len - CNT_W'(1)) begin
                    n_state = S_SQST;
                end else begin
                    n_k = r_k + ADDR_W'(1);
                    o_cmd.bin_start = 1'b1;
                    n_state = S_MAC;
                end
            end
            S_SQST: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) n_state = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.res_write = 1'b1;
                    o_cmd.res_bad   = r_bad;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_len   <= CNT_W'(MAX_LEN);
            r_lg    <= '0;
            r_k     <= '0;
            r_n     <= '0;
            r_drain <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_len   <= n_len;
            r_lg    <= n_lg;
            r_k     <= n_k;
            r_n     <= n_n;
            r_drain <= n_drain;
            r_bad   <= n_bad;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);
endmodule
`default_nettype wire

// ===== sim/iq_dft_peak_band_power_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module iq_dft_peak_band_power_checker import idpbp_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire logic signed [SMP_W-1:0] i_sample_i,
    input  wire logic signed [SMP_W-1:0] i_sample_q,
    input  wire logic                    i_last,
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [BAND_W-1:0]       i_cfg_data,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic [1:0]              i_status,
    input  wire logic signed [PEAK_W-1:0] i_max_bin,
    input  wire logic [POW_W-1:0]        i_max_power,
    input  wire logic [SUM_W-1:0]        i_band_power,
    input  wire logic                    i_band_saturated,
    input  wire logic [POW_W-1:0]        i_probe_power,
    input  wire logic [ROOT_W-1:0]       i_probe_magnitude,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_results
);

    typedef struct {
        logic [1:0]               status;
        logic signed [PEAK_W-1:0] max_bin;
        logic [POW_W-1:0]         max_power;
        logic [SUM_W-1:0]         band_power;
        logic                     band_sat;
        logic [POW_W-1:0]         probe_power;
        logic [ROOT_W-1:0]        probe_mag;
    } t_spectrum;

    localparam longint unsigned CAP = 64'h7FFF_FFFF_FFFF_FFFF;

    t_spectrum             spectra_q[$];
    longint                sine_tab[0:QUARTER];
    logic signed [SMP_W-1:0] buf_i[MAX_LEN];
    logic signed [SMP_W-1:0] buf_q[MAX_LEN];
    int                    fill;
    logic [PROBE_W-1:0]    probe_reg;
    logic signed [BAND_W-1:0] band_lo;
    logic signed [BAND_W-1:0] band_hi;

    assign o_pending = spectra_q.size();

    // quarter sine, Taylor series in Q30, rounded to Q1.15
    initial begin
        longint unsigned x, x2, term;
        longint          sum, r;
        for (int j = 0; j <= QUARTER; j++) begin
            x = longint'(j) * 64'd6746518852 / MAX_LEN;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            r = (sum + (64'sd1 <<< (30 - TW_W))) >>> (31 - TW_W);
            sine_tab[j] = (r > 32767) ? 32767 : r;
        end
    end

    function automatic longint twiddle(int t);
        int ph, r;
        ph = t & (MAX_LEN - 1);
        r = ph % QUARTER;
        case (ph / QUARTER)
            0: return sine_tab[r];
            1: return sine_tab[QUARTER - r];
            2: return -sine_tab[r];
            default: return -sine_tab[QUARTER - r];
        endcase
    endfunction

    function automatic longint unsigned square_cap(longint v);
        longint unsigned u;
        u = (v < 0) ? longint'(-v) : v;
        if (u > 64'd3037000499) return CAP;
        return u * u;
    endfunction

    function automatic longint unsigned power_of_bin(int k, int n_len, int lg);
        longint re, im, c, s;
        int step, t;
        longint unsigned a, b, p;
        step = MAX_LEN / n_len;
        re = 0;
        im = 0;
        for (int n = 0; n < n_len; n++) begin
            t = ((k * n) & (n_len - 1)) * step;
            c = twiddle(t + QUARTER);
            s = twiddle(t);
            re += longint'(buf_i[n]) * c + longint'(buf_q[n]) * s;
            im += longint'(buf_q[n]) * c - longint'(buf_i[n]) * s;
        end
        re = re >>> lg;   // floor division by N
        im = im >>> lg;
        a = square_cap(re);
        b = square_cap(im);
        p = a + b;
        if (p < a || p > CAP) p = CAP;
        return p;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic t_spectrum transform(int n_len);
        t_spectrum        e;
        int               lg, probe, best_k, sb;
        bit               inverted, sat;
        longint unsigned  p, best_p, sum, t, probe_p;
        e = '{default: '0};
        if (n_len == 0 || n_len > MAX_LEN || (n_len & (n_len - 1)) != 0) begin
            e.status = ST_BAD_LEN;
            return e;
        end
        lg = 0;
        while ((1 << lg) < n_len) lg++;
        inverted = band_lo > band_hi;
        probe = int'(probe_reg) & (n_len - 1);
        sat = 0;
        sum = 0;
        best_p = 0;
        best_k = 0;
        probe_p = 0;
        for (int k = 0; k < n_len; k++) begin
            p = power_of_bin(k, n_len, lg);
            if (k == 0 || p > best_p) begin
                best_p = p;
                best_k = k;
            end
            sb = (k > n_len / 2) ? k - n_len : k;
            if (!inverted && sb >= band_lo && sb <= band_hi) begin
                t = sum + p;
                if (t < sum) begin
                    t = '1;
                    sat = 1;
                end
                sum = t;
            end
            if (k == probe) probe_p = p;
        end
        e.status = inverted ? ST_BAND_BAD : ST_OK;
        e.max_bin = PEAK_W'((best_k > n_len / 2) ? best_k - n_len : best_k);
        e.max_power = best_p[POW_W-1:0];
        e.band_power = inverted ? '0 : sum;
        e.band_sat = !inverted && sat;
        e.probe_power = probe_p[POW_W-1:0];
        e.probe_mag = int_sqrt(probe_p) & 64'hFFFF_FFFF;
        return e;
    endfunction

    task automatic note_mismatch(string what, longint unsigned exp_v, longint unsigned act_v);
        o_errors++;
        if (o_errors <= 10)
            $display("mismatch on result %0d, %s: expected %0h got %0h",
                     o_results, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_spectrum e;
        if (!i_rst_n) begin
            fill = 0;
            probe_reg = '0;
            band_lo = -11'sd512;
            band_hi = 11'sd512;
            spectra_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROBE:     probe_reg = i_cfg_data[PROBE_W-1:0];
                    CFG_BAND_LOW:  band_lo = i_cfg_data;
                    CFG_BAND_HIGH: band_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (fill < MAX_LEN) begin
                    buf_i[fill] = i_sample_i;
                    buf_q[fill] = i_sample_q;
                    fill++;
                end else begin
                    fill = MAX_LEN + 1;
                end
                if (i_last) begin
                    spectra_q.push_back(transform(fill));
                    fill = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (spectra_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("result beat with nothing expected");
                end else begin
                    e = spectra_q.pop_front();
                    if (i_status !== e.status) note_mismatch("status", e.status, i_status);
                    if (i_max_bin !== e.max_bin)
                        note_mismatch("max_bin", 64'(e.max_bin), 64'(i_max_bin));
                    if (i_max_power !== e.max_power)
                        note_mismatch("max_power", e.max_power, i_max_power);
                    if (i_band_power !== e.band_power)
                        note_mismatch("band_power", e.band_power, i_band_power);
                    if (i_band_saturated !== e.band_sat)
                        note_mismatch("band_saturated", e.band_sat, i_band_saturated);
                    if (i_probe_power !== e.probe_power)
                        note_mismatch("probe_power", e.probe_power, i_probe_power);
                    if (i_probe_magnitude !== e.probe_mag)
                        note_mismatch("probe_magnitude", e.probe_mag, i_probe_magnitude);
                end
                o_results++;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_iq_dft_peak_band_power_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_iq_dft_peak_band_power_unit;
    import idpbp_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 3000;

    logic                     clk = 0;
    logic                     rst_n = 0;
    logic                     in_valid = 0;
    logic                     in_stall;
    logic signed [SMP_W-1:0]  sample_i = '0;
    logic signed [SMP_W-1:0]  sample_q = '0;
    logic                     last = 0;
    logic                     cfg_valid = 0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = CFG_PROBE;
    logic [BAND_W-1:0]        cfg_data = '0;
    logic                     out_valid;
    logic                     out_stall = 0;
    logic [1:0]               status;
    logic signed [PEAK_W-1:0] max_bin;
    logic [POW_W-1:0]         max_power;
    logic [SUM_W-1:0]         band_power;
    logic                     band_saturated;
    logic [POW_W-1:0]         probe_power;
    logic [ROOT_W-1:0]        probe_magnitude;
    int                       errors, pending, results;
    int                       cycles = 0;
    int                       beats = 0;
    int                       buffers = 0;
    bit                       hold_req = 0;

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    iq_dft_peak_band_power_unit DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_sample_i(sample_i), .i_sample_q(sample_q), .i_last(last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_max_bin(max_bin), .o_max_power(max_power),
        .o_band_power(band_power), .o_band_saturated(band_saturated),
        .o_probe_power(probe_power), .o_probe_magnitude(probe_magnitude)
    );

    iq_dft_peak_band_power_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_sample_i(sample_i), .i_sample_q(sample_q), .i_last(last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_max_bin(max_bin), .i_max_power(max_power),
        .i_band_power(band_power), .i_band_saturated(band_saturated),
        .i_probe_power(probe_power), .i_probe_magnitude(probe_magnitude),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls; one long hold-off on request
    always begin
        int n;
        @(negedge clk);
        if (hold_req) begin
            out_stall = 1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 0;
            out_stall = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            out_stall = 0;
            repeat ($urandom_range(20, 80)) @(negedge clk);
        end else begin
            n = gap_len();
            out_stall = (n != 0);
            repeat (n) @(negedge clk);
        end
    end

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return SMP_W'($urandom());
        endcase
    endfunction

    task automatic send_beat(logic [SMP_W-1:0] si, logic [SMP_W-1:0] sq, bit lst, int gap);
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1;
        sample_i = si;
        sample_q = sq;
        last = lst;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        beats++;
    endtask

    task automatic send_buffer(int len, bit gaps);
        for (int n = 0; n < len; n++)
            send_beat(rand_sample(), rand_sample(), n == len - 1, gaps ? gap_len() : 0);
        buffers++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = BAND_W'(val);
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic random_config();
        int lo, hi;
        write_reg(CFG_PROBE, $urandom_range(0, 1023));
        lo = $urandom_range(0, 1024) - 512;
        hi = $urandom_range(0, 1024) - 512;
        if ($urandom_range(0, 3) != 0 && lo > hi) begin
            int t;
            t = lo;
            lo = hi;
            hi = t;
        end
        if ($urandom_range(0, 5) == 0) begin
            lo = -$urandom_range(0, 20);
            hi = $urandom_range(0, 20);
        end
        write_reg(CFG_BAND_LOW, lo);
        write_reg(CFG_BAND_HIGH, hi);
    endtask

    initial begin
        int len, r;
        repeat (2) @(negedge clk);
        rst_n = 1;

        // directed: extremes, single-sample buffer, all-min samples
        send_beat(16'h7FFF, 16'h8000, 1, 0);
        buffers++;
        send_beat(16'h8000, 16'h8000, 0, 0);
        send_beat(16'h8000, 16'h8000, 1, 0);
        buffers++;
        // tone at bin N/2 reports as +N/2
        for (int n = 0; n < 4; n++)
            send_beat(n[0] ? -16'sd20000 : 16'sd20000, '0, n == 3, 0);
        buffers++;
        // all zero: every bin ties, bin 0 wins
        for (int n = 0; n < 4; n++) send_beat('0, '0, n == 3, 0);
        buffers++;
        send_buffer(3, 0);      // bad length
        drain();
        write_reg(CFG_BAND_LOW, 5);
        write_reg(CFG_BAND_HIGH, -5);
        send_buffer(4, 0);      // inverted band
        drain();
        write_reg(CFG_PROBE, 1023);
        write_reg(CFG_BAND_LOW, 0);
        write_reg(CFG_BAND_HIGH, 0);
        send_buffer(4, 1);
        drain();
        write_reg(CFG_BAND_LOW, -512);
        write_reg(CFG_BAND_HIGH, 512);

        while (beats < 580) begin
            if (buffers % 30 == 0) begin
                drain();
                random_config();
            end
            if (buffers == 20) begin
                // receiver holds off while buffers keep coming
                hold_req = 1;
                for (int b = 0; b < 6; b++) send_buffer(16, 0);
            end
            if (buffers == 32) send_buffer(256, 0);
            r = $urandom_range(0, 99);
            if (r < 70) len = 1 << $urandom_range(0, 5);
            else if (r < 92) len = $urandom_range(1, 40);
            else len = 1 << $urandom_range(6, 7);
            send_buffer(len, 1);
        end

        @(negedge clk);
        in_valid = 0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("%0d beats in %0d buffers, %0d results checked, %0d mismatches",
                 beats, buffers, results, errors);
        $display("covered bad lengths, inverted band, long output hold-off");
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/idpbp_pkg.sv
rtl/core/idpbp_isqrt.sv
rtl/core/idpbp_datapath.sv
rtl/core/idpbp_ctrl.sv
rtl/core/iq_dft_peak_band_power_unit.sv
sim/iq_dft_peak_band_power_checker.sv
sim/tb_iq_dft_peak_band_power_unit.sv
